>>> hw/rtl/ihcc_pkg.sv
package ihcc_pkg;

   localparam int ADDR_W           = 32;
   localparam int CNT_W            = 32;
   localparam int SLOT_W           = 6;
   localparam int HOST_ENTRIES_DEF = 64;
   localparam int PAIR_ENTRIES_DEF = 64;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // broadcast to every host cell
   typedef struct packed {
      logic              dst_pass;   // 0: source pass (sent), 1: destination pass (received)
      logic              upd;
      logic              ins;
      logic [ADDR_W-1:0] addr;
   } host_op_type;

   // broadcast to every pair cell
   typedef struct packed {
      logic              upd;
      logic              ins;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } pair_op_type;

   // returned by every cell: match flag and the count after increment
   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] cnt;
   } cell_res_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = (v == CNT_MAX) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

>>> hw/rtl/ihcc_host_cell.sv
module ihcc_host_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic                   clock,
   input  ihcc_pkg::host_op_type  op,
   input  logic [CW-1:0]          used,
   output ihcc_pkg::cell_res_type res
);

   logic [ihcc_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [ihcc_pkg::CNT_W-1:0]  sent_ff, sent_in;
   logic [ihcc_pkg::CNT_W-1:0]  recv_ff, recv_in;
   logic                        live;
   logic                        hit;
   logic                        fill;
   logic [ihcc_pkg::CNT_W-1:0]  nxt;

   assign live = CW'(INDEX) < used;
   assign hit  = live && (addr_ff == op.addr);
   assign fill = op.ins && (used == CW'(INDEX));
   assign nxt  = ihcc_pkg::sat_inc(op.dst_pass ? recv_ff : sent_ff);

   assign res.hit = hit;
   assign res.cnt = hit ? nxt : '0;

   always_comb begin
      addr_in = addr_ff;
      sent_in = sent_ff;
      recv_in = recv_ff;
      if (op.upd && hit) begin
         if (op.dst_pass) begin
            recv_in = nxt;
         end else begin
            sent_in = nxt;
         end
      end else if (fill) begin
         addr_in = op.addr;
         sent_in = op.dst_pass ? '0 : ihcc_pkg::CNT_W'(1);
         recv_in = op.dst_pass ? ihcc_pkg::CNT_W'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      sent_ff <= sent_in;
      recv_ff <= recv_in;
   end

endmodule

>>> hw/rtl/ihcc_pair_cell.sv
module ihcc_pair_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic                   clock,
   input  ihcc_pkg::pair_op_type  op,
   input  logic [CW-1:0]          used,
   output ihcc_pkg::cell_res_type res
);

   logic [ihcc_pkg::ADDR_W-1:0] first_ff, first_in;
   logic [ihcc_pkg::ADDR_W-1:0] second_ff, second_in;
   logic [ihcc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        live;
   logic                        hit;
   logic                        fill;
   logic [ihcc_pkg::CNT_W-1:0]  nxt;

   // unordered match
   assign live = CW'(INDEX) < used;
   assign hit  = live && (((first_ff == op.addr_a) && (second_ff == op.addr_b)) ||
                          ((first_ff == op.addr_b) && (second_ff == op.addr_a)));
   assign fill = op.ins && (used == CW'(INDEX));
   assign nxt  = ihcc_pkg::sat_inc(cnt_ff);

   assign res.hit = hit;
   assign res.cnt = hit ? nxt : '0;

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      cnt_in    = cnt_ff;
      if (op.upd && hit) begin
         cnt_in = nxt;
      end else if (fill) begin
         first_in  = op.addr_a;
         second_in = op.addr_b;
         cnt_in    = ihcc_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      cnt_ff    <= cnt_in;
   end

endmodule

>>> hw/rtl/ip_host_and_conversation_counters.sv
// IPv4 host and conversation counters. Each request transaction carries the source and
// destination address of one packet. A row of host cells keeps addresses in arrival order
// with a saturating sent and received count each; a row of pair cells keeps unordered
// address pairs with a saturating packet count. Every cell compares the broadcast key
// against its own entry in parallel, and the free cell at the fill count takes a new entry.
// Each item has two steps: the source lookup and the pair lookup run in the accept cycle,
// the destination lookup (which may hit the entry the source just created) in ST_DST after it.
// The destination cycle waits while the previous response is still held. A new request
// is taken while a finished response waits. Slots report the low 6 bits of the entry
// index; on a miss with a full table the slot and count are zero and the full flag is set.
module ip_host_and_conversation_counters #(
   parameter int HOST_ENTRIES = ihcc_pkg::HOST_ENTRIES_DEF,
   parameter int PAIR_ENTRIES = ihcc_pkg::PAIR_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // src_addr[31:0], dst_addr[63:32]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // src_slot, src_sent, dst_slot, dst_received,
                                     // pair_slot, pair_count, zero pad
   output logic [1:0]   rsp_tuser    // host_full, pair_full
);

   localparam int ADDR_W = ihcc_pkg::ADDR_W;
   localparam int CNT_W  = ihcc_pkg::CNT_W;
   localparam int SLOT_W = ihcc_pkg::SLOT_W;
   localparam int HIW    = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
   localparam int HCW    = $clog2(HOST_ENTRIES + 1);
   localparam int PIW    = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
   localparam int PCW    = $clog2(PAIR_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_SRC = 2'b01,
      ST_DST = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [HCW-1:0] hosts_used_ff, hosts_used_in;
   logic [PCW-1:0] pairs_used_ff, pairs_used_in;

   logic [ADDR_W-1:0] dst_ff;
   logic [SLOT_W-1:0] src_slot_ff, pair_slot_ff;
   logic [CNT_W-1:0]  src_sent_ff, pair_count_ff;
   logic              src_full_ff, pair_full_ff;

   logic              rsp_valid_ff;
   logic [119:0]      rsp_data_ff;
   logic [1:0]        rsp_user_ff;

   logic [ADDR_W-1:0] req_src, req_dst;
   logic              src_go, dst_go, out_free, host_go;

   ihcc_pkg::host_op_type  host_op;
   ihcc_pkg::pair_op_type  pair_op;
   ihcc_pkg::cell_res_type host_res [HOST_ENTRIES];
   ihcc_pkg::cell_res_type pair_res [PAIR_ENTRIES];

   logic             h_any, p_any;
   logic [CNT_W-1:0] h_cnt, p_cnt;
   logic [HIW-1:0]   h_idx;
   logic [PIW-1:0]   p_idx;
   logic             h_full_tab, p_full_tab;
   logic [CNT_W-1:0] h_val, p_val;
   logic [SLOT_W-1:0] h_slot, p_slot;

   assign req_src = req_tdata[31:0];
   assign req_dst = req_tdata[63:32];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_SRC);
   assign src_go     = req_tready && req_tvalid;
   assign dst_go     = (state_ff == ST_DST) && out_free;
   assign host_go    = src_go || dst_go;

   assign h_full_tab = (hosts_used_ff == HCW'(HOST_ENTRIES));
   assign p_full_tab = (pairs_used_ff == PCW'(PAIR_ENTRIES));

   assign host_op.dst_pass = (state_ff == ST_DST);
   assign host_op.addr     = (state_ff == ST_DST) ? dst_ff : req_src;
   assign host_op.upd      = host_go;
   assign host_op.ins      = host_go && !h_any && !h_full_tab;

   assign pair_op.addr_a = req_src;
   assign pair_op.addr_b = req_dst;
   assign pair_op.upd    = src_go;
   assign pair_op.ins    = src_go && !p_any && !p_full_tab;

   for (genvar i = 0; i < HOST_ENTRIES; i++) begin : g_host
      ihcc_host_cell #(.INDEX(i), .CW(HCW)) u_cell (
         .clock (clock),
         .op    (host_op),
         .used  (hosts_used_ff),
         .res   (host_res[i])
      );
   end

   for (genvar i = 0; i < PAIR_ENTRIES; i++) begin : g_pair
      ihcc_pair_cell #(.INDEX(i), .CW(PCW)) u_cell (
         .clock (clock),
         .op    (pair_op),
         .used  (pairs_used_ff),
         .res   (pair_res[i])
      );
   end

   // entries are unique, so at most one cell hits
   always_comb begin
      h_any = 1'b0;
      h_cnt = '0;
      h_idx = '0;
      for (int i = 0; i < HOST_ENTRIES; i++) begin
         h_any = h_any | host_res[i].hit;
         h_cnt = h_cnt | host_res[i].cnt;
         if (host_res[i].hit) begin
            h_idx = h_idx | HIW'(i);
         end
      end
   end

   always_comb begin
      p_any = 1'b0;
      p_cnt = '0;
      p_idx = '0;
      for (int i = 0; i < PAIR_ENTRIES; i++) begin
         p_any = p_any | pair_res[i].hit;
         p_cnt = p_cnt | pair_res[i].cnt;
         if (pair_res[i].hit) begin
            p_idx = p_idx | PIW'(i);
         end
      end
   end

   always_comb begin
      if (h_any) begin
         h_val  = h_cnt;
         h_slot = SLOT_W'(h_idx);
      end else if (h_full_tab) begin
         h_val  = '0;
         h_slot = '0;
      end else begin
         h_val  = CNT_W'(1);
         h_slot = SLOT_W'(HIW'(hosts_used_ff));
      end
      if (p_any) begin
         p_val  = p_cnt;
         p_slot = SLOT_W'(p_idx);
      end else if (p_full_tab) begin
         p_val  = '0;
         p_slot = '0;
      end else begin
         p_val  = CNT_W'(1);
         p_slot = SLOT_W'(PIW'(pairs_used_ff));
      end
   end

   always_comb begin
      state_in      = state_ff;
      hosts_used_in = hosts_used_ff;
      pairs_used_in = pairs_used_ff;
      if (host_op.ins) begin
         hosts_used_in = hosts_used_ff + 1'b1;
      end
      if (pair_op.ins) begin
         pairs_used_in = pairs_used_ff + 1'b1;
      end
      unique case (state_ff)
         ST_SRC: begin
            if (src_go) begin
               state_in = ST_DST;
            end
         end
         ST_DST: begin
            if (dst_go) begin
               state_in = ST_SRC;
            end
         end
         default: state_in = ST_SRC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SRC;
         hosts_used_ff <= '0;
         pairs_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hosts_used_ff <= hosts_used_in;
         pairs_used_ff <= pairs_used_in;
         if (dst_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (src_go) begin
         dst_ff        <= req_dst;
         src_slot_ff   <= h_slot;
         src_sent_ff   <= h_val;
         src_full_ff   <= !h_any && h_full_tab;
         pair_slot_ff  <= p_slot;
         pair_count_ff <= p_val;
         pair_full_ff  <= !p_any && p_full_tab;
      end
      if (dst_go) begin
         rsp_data_ff <= {6'b0, pair_count_ff, pair_slot_ff, h_val, h_slot,
                         src_sent_ff, src_slot_ff};
         rsp_user_ff <= {pair_full_ff, src_full_ff || (!h_any && h_full_tab)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
